// ----- src/gbp_pkg.sv -----
// Package for the gshare branch predictor.
// Holds shared constants, the controller state type and command/status structs.
// No dependencies.
`default_nettype none

package gbp_pkg;

  localparam int INDEX_BITS_DEF = 12;
  localparam int HIST_MAX       = 12;
  localparam int CFG_W          = 4;
  localparam int PC_W           = 32;
  localparam int CNT_W          = 32;
  localparam int CTR_W          = 2;
  localparam int IN_W           = 40;
  localparam int OUT_W          = 72;

  localparam logic [CFG_W-1:0] HIST_BITS_RESET = 4'd8;
  localparam logic [CTR_W-1:0] CTR_RESET       = 2'd2;
  localparam logic [CTR_W-1:0] CTR_MAX         = 2'd3;
  localparam logic [CTR_W-1:0] CTR_MIN         = 2'd0;
  localparam logic [CNT_W-1:0] CNT_MAX         = '1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic update;
  } gbp_cmd_t;

  typedef struct packed {
    logic clr_last;
  } gbp_sts_t;

endpackage

`default_nettype wire

// ----- src/gbp_ctrl.sv -----
// Controller state machine of the gshare branch predictor.
// Sequences table clearing, item load and update, and owns the output valid.
// Depends on gbp_pkg.
`default_nettype none

module gbp_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  input  wire gbp_pkg::gbp_sts_t sts,
  output gbp_pkg::gbp_cmd_t      cmd
);

  gbp_pkg::state_t state;
  gbp_pkg::state_t state_next;
  logic            out_valid;
  logic            out_valid_next;
  logic            out_free;

  assign out_free      = !out_valid || m_axis_tready;
  assign m_axis_tvalid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gbp_pkg::ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    s_axis_tready = 1'b0;
    case (state)
      gbp_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = gbp_pkg::ST_IDLE;
        end
      end
      gbp_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd.load   = 1'b1;
          state_next = gbp_pkg::ST_UPDATE;
        end
      end
      gbp_pkg::ST_UPDATE: begin
        if (out_free) begin
          cmd.update = 1'b1;
          state_next = gbp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = gbp_pkg::ST_CLEAR;
      end
    endcase
    if (cmd.update) begin
      out_valid_next = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second item accepted before update");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> (!m_axis_tvalid || m_axis_tready))
    else $error("pending result overwritten");

  a_update_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.update |=> m_axis_tvalid)
    else $error("update did not present a result");

  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    (state == gbp_pkg::ST_CLEAR && sts.clr_last) |=> s_axis_tready)
    else $error("not ready after clearing pass");
`endif

endmodule

`default_nettype wire

// ----- src/gbp_datapath.sv -----
// Datapath of the gshare branch predictor.
// Holds the counter table, history, config register, running counts and index logic.
// Depends on gbp_pkg; driven by gbp_ctrl commands.
`default_nettype none

module gbp_datapath #(
  parameter int INDEX_BITS = gbp_pkg::INDEX_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire gbp_pkg::gbp_cmd_t          cmd,
  output gbp_pkg::gbp_sts_t               sts,
  input  wire logic                       cfg_valid,
  input  wire logic [gbp_pkg::CFG_W-1:0]  cfg_data,
  input  wire logic [gbp_pkg::IN_W-1:0]   in_data,
  output logic [gbp_pkg::OUT_W-1:0]       out_data
);

  localparam int DEPTH = 1 << INDEX_BITS;
  localparam int HW    = gbp_pkg::HIST_MAX;
  localparam int LOW_W = $clog2(INDEX_BITS + 1);

  logic [gbp_pkg::CTR_W-1:0] mem [DEPTH];

  logic [gbp_pkg::CFG_W-1:0] hist_bits;
  logic [HW-1:0]             hist;
  logic [HW-1:0]             hist_next;
  logic [gbp_pkg::CNT_W-1:0] pred_cnt;
  logic [gbp_pkg::CNT_W-1:0] miss_cnt;
  logic [INDEX_BITS-1:0]     clr_addr;
  logic [INDEX_BITS-1:0]     idx;
  logic [INDEX_BITS-1:0]     idx_q;
  logic                      tk_q;
  logic [gbp_pkg::CTR_W-1:0] rd_ctr;
  logic [gbp_pkg::CTR_W-1:0] ctr_next;
  logic                      out_pred;
  logic                      out_miss;
  logic                      pred;
  logic                      miss;

  logic [gbp_pkg::CFG_W-1:0] n;
  logic [LOW_W-1:0]          low;
  logic [HW-1:0]             nmask;
  logic [INDEX_BITS+HW-1:0]  hsh;
  logic [gbp_pkg::PC_W-1:0]  pc_in;
  logic                      tk_in;

  logic                      mem_we;
  logic [INDEX_BITS-1:0]     mem_wa;
  logic [gbp_pkg::CTR_W-1:0] mem_wd;

  assign pc_in = in_data[gbp_pkg::PC_W-1:0];
  assign tk_in = in_data[gbp_pkg::PC_W];

  always_comb begin
    n = hist_bits;
    if (n == '0) begin
      n = gbp_pkg::CFG_W'(1);
    end
    if (n > gbp_pkg::CFG_W'(HW)) begin
      n = gbp_pkg::CFG_W'(HW);
    end
    if (int'(n) > INDEX_BITS) begin
      n = gbp_pkg::CFG_W'(INDEX_BITS);
    end
  end

  assign low   = LOW_W'(INDEX_BITS) - LOW_W'(n);
  assign nmask = (HW'(1) << n) - HW'(1);
  assign hsh   = {{INDEX_BITS{1'b0}}, hist & nmask} << low;
  assign idx   = pc_in[2 +: INDEX_BITS] ^ hsh[INDEX_BITS-1:0];

  assign pred = rd_ctr[1];
  assign miss = pred ^ tk_q;

  always_comb begin
    ctr_next = rd_ctr;
    if (tk_q) begin
      if (rd_ctr != gbp_pkg::CTR_MAX) begin
        ctr_next = rd_ctr + gbp_pkg::CTR_W'(1);
      end
    end else if (rd_ctr != gbp_pkg::CTR_MIN) begin
      ctr_next = rd_ctr - gbp_pkg::CTR_W'(1);
    end
    hist_next = (hist >> 1) & nmask;
    if (tk_q) begin
      hist_next = hist_next | (HW'(1) << (n - gbp_pkg::CFG_W'(1)));
    end
  end

  assign mem_we = cmd.clr_step || cmd.update;
  assign mem_wa = cmd.clr_step ? clr_addr : idx_q;
  assign mem_wd = cmd.clr_step ? gbp_pkg::CTR_RESET : ctr_next;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.load) begin
      rd_ctr <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_q <= idx;
      tk_q  <= tk_in;
    end
    if (cmd.update) begin
      out_pred <= pred;
      out_miss <= miss;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_bits <= gbp_pkg::HIST_BITS_RESET;
      hist      <= '0;
      pred_cnt  <= '0;
      miss_cnt  <= '0;
      clr_addr  <= '0;
    end else begin
      if (cfg_valid) begin
        hist_bits <= cfg_data;
      end
      if (cmd.clr_step) begin
        clr_addr <= clr_addr + INDEX_BITS'(1);
      end
      if (cmd.update) begin
        hist <= hist_next;
        if (pred_cnt != gbp_pkg::CNT_MAX) begin
          pred_cnt <= pred_cnt + gbp_pkg::CNT_W'(1);
        end
        if (miss && miss_cnt != gbp_pkg::CNT_MAX) begin
          miss_cnt <= miss_cnt + gbp_pkg::CNT_W'(1);
        end
      end
    end
  end

  assign sts.clr_last = (clr_addr == {INDEX_BITS{1'b1}});
  assign out_data     = {6'b0, miss_cnt, pred_cnt, out_miss, out_pred};

endmodule

`default_nettype wire

// ----- src/gshare_branch_predictor.sv -----
// Top level of the gshare branch predictor.
// Joins the gbp_ctrl state machine and the gbp_datapath; depends on gbp_pkg.
//
// Each transfer on the input stream brings one resolved branch; one result is
// returned per branch with the prediction made before training and the running
// prediction and misprediction counts. After reset the counter table is swept
// to weakly taken, one entry per cycle over all 2^INDEX_BITS entries, during
// which no branch is taken in. After that each branch reads its counter from the
// single-port table, then writes the trained counter back once the output is free.
// A finished result waits in the output register while the next branch is taken
// in. history_bits may be written only while no branch is in flight.
`default_nettype none

module gshare_branch_predictor #(
  parameter int INDEX_BITS = gbp_pkg::INDEX_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [gbp_pkg::CFG_W-1:0]  cfg_data,      // history_bits
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [gbp_pkg::IN_W-1:0]   s_axis_tdata,  // branch_pc, taken
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic [gbp_pkg::OUT_W-1:0]       m_axis_tdata   // predicted_taken, mispredicted,
                                                         // prediction_total, mispredict_total
);

  gbp_pkg::gbp_cmd_t cmd;
  gbp_pkg::gbp_sts_t sts;

  assign cfg_ready = 1'b1;

  gbp_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .sts           (sts),
    .cmd           (cmd)
  );

  gbp_datapath #(
    .INDEX_BITS (INDEX_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .out_data  (m_axis_tdata)
  );

endmodule

`default_nettype wire
